// ----- sv/efc_pkg.sv -----
// Shared types and constants for the EtherCAT frame checker.
// No dependencies; imported by every module of the block.
`default_nettype none
package efc_pkg;

   localparam int unsigned CountWidth  = 11;
   localparam int unsigned OffsetWidth = 12;

   localparam logic [CountWidth-1:0]  MAX_FRAME      = 11'd1518;
   localparam logic [CountWidth-1:0]  MIN_FRAME      = 11'd28;
   localparam logic [CountWidth-1:0]  POS_TYPE_HI    = 11'd12;
   localparam logic [CountWidth-1:0]  POS_TYPE_LO    = 11'd13;
   localparam logic [CountWidth-1:0]  POS_HDR_LO     = 11'd14;
   localparam logic [CountWidth-1:0]  POS_HDR_HI     = 11'd15;
   localparam logic [OffsetWidth-1:0] HDR_BASE       = 12'd16;
   localparam logic [OffsetWidth:0]   DGRAM_LEN_LO   = 13'd6;
   localparam logic [OffsetWidth:0]   DGRAM_LEN_HI   = 13'd7;
   localparam logic [OffsetWidth:0]   DGRAM_OVERHEAD = 13'd12;
   localparam logic [7:0]             ETHERTYPE_HI   = 8'h88;
   localparam logic [7:0]             ETHERTYPE_LO   = 8'ha4;
   localparam logic [3:0]             HDR_TYPE_PDU   = 4'd1;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        frame_end;
      logic [15:0] wire_length;
   } req_word_type;

   typedef struct packed {
      logic                  frame_ok;
      logic [CountWidth-1:0] captured_length;
   } rsp_word_type;

endpackage
`default_nettype wire

// ----- sv/efc_walker.sv -----
// Per-frame state: byte count, header fields and datagram chain walk.
// Produces the verdict for the byte being accepted. Uses efc_pkg.
`default_nettype none
module efc_walker (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire efc_pkg::req_word_type in_word,
   output efc_pkg::rsp_word_type      verdict
);
   import efc_pkg::*;

   logic [CountWidth-1:0]  byte_count_ff, byte_count_in;
   logic [7:0]             low_byte_ff, low_byte_in;
   logic [OffsetWidth-1:0] payload_end_ff, payload_end_in;
   logic [OffsetWidth-1:0] dgram_start_ff, dgram_start_in;
   logic                   walk_done_ff, walk_done_in;
   logic                   frame_bad_ff, frame_bad_in;

   logic [OffsetWidth:0]   start_ext;
   logic [OffsetWidth:0]   end_ext;
   logic [OffsetWidth:0]   pos_ext;
   logic [OffsetWidth:0]   next_ofs;
   logic [CountWidth-1:0]  len_field;
   logic                   more;
   logic [7:0]             b;

   always_comb begin
      b              = in_word.data_byte;
      byte_count_in  = byte_count_ff;
      low_byte_in    = low_byte_ff;
      payload_end_in = payload_end_ff;
      dgram_start_in = dgram_start_ff;
      walk_done_in   = walk_done_ff;
      frame_bad_in   = frame_bad_ff;
      start_ext      = {1'b0, dgram_start_ff};
      end_ext        = {1'b0, payload_end_ff};
      pos_ext        = {2'b00, byte_count_ff};
      len_field      = {b[2:0], low_byte_ff};
      more           = b[7];
      next_ofs       = start_ext + DGRAM_OVERHEAD + {2'b00, len_field};

      if (byte_count_ff <= MAX_FRAME) begin
         byte_count_in = byte_count_ff + 11'd1;
         if (byte_count_ff == POS_TYPE_HI) begin
            if (b != ETHERTYPE_HI) frame_bad_in = 1'b1;
         end else if (byte_count_ff == POS_TYPE_LO) begin
            if (b != ETHERTYPE_LO) frame_bad_in = 1'b1;
         end else if (byte_count_ff == POS_HDR_LO) begin
            low_byte_in = b;
         end else if (byte_count_ff == POS_HDR_HI) begin
            payload_end_in = HDR_BASE + {1'b0, len_field};
            if (b[7:4] != HDR_TYPE_PDU || b[3]) frame_bad_in = 1'b1;
            if (len_field == '0) walk_done_in = 1'b1;
         end else if (pos_ext >= {1'b0, HDR_BASE} && !walk_done_ff && !frame_bad_ff) begin
            if (pos_ext == start_ext + DGRAM_LEN_LO) begin
               low_byte_in = b;
            end else if (pos_ext == start_ext + DGRAM_LEN_HI) begin
               if (end_ext < start_ext + DGRAM_OVERHEAD) begin
                  frame_bad_in = 1'b1;
               end else if (next_ofs > end_ext) begin
                  frame_bad_in = 1'b1;
               end else if (more == (next_ofs == end_ext)) begin
                  frame_bad_in = 1'b1;
               end else if (next_ofs == end_ext) begin
                  walk_done_in = 1'b1;
               end else begin
                  dgram_start_in = next_ofs[OffsetWidth-1:0];
               end
            end
         end
      end

      verdict.captured_length = byte_count_in;
      verdict.frame_ok = !frame_bad_in && walk_done_in
         && byte_count_in >= MIN_FRAME
         && {5'b00000, byte_count_in} == in_word.wire_length
         && byte_count_in <= MAX_FRAME
         && payload_end_in <= {1'b0, byte_count_in};
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && in_word.frame_end)) begin
         byte_count_ff  <= '0;
         low_byte_ff    <= '0;
         payload_end_ff <= '0;
         dgram_start_ff <= HDR_BASE;
         walk_done_ff   <= 1'b0;
         frame_bad_ff   <= 1'b0;
      end else if (accept) begin
         byte_count_ff  <= byte_count_in;
         low_byte_ff    <= low_byte_in;
         payload_end_ff <= payload_end_in;
         dgram_start_ff <= dgram_start_in;
         walk_done_ff   <= walk_done_in;
         frame_bad_ff   <= frame_bad_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/ethercat_frame_checker_unit.sv -----
// Top level of the EtherCAT frame checker: handshake and result register.
// Depends on efc_pkg and efc_walker.
//
// Takes one received frame byte per clock in wire order and returns one
// accept/reject word for each byte marked frame_end, in the cycle after that
// byte is accepted. All checks run on the byte as it is accepted; the only
// pipeline stage is the result register, so req_ready drops only while a
// result sits there untaken.
`default_nettype none
module ethercat_frame_checker_unit (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire efc_pkg::req_word_type req_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output efc_pkg::rsp_word_type      rsp_word
);
   import efc_pkg::*;

   logic         accept;
   rsp_word_type verdict;
   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   efc_walker u_walker (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_word (req_word),
      .verdict (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && req_word.frame_end) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_word.frame_end) begin
         rsp_word_ff <= verdict;
      end
   end

endmodule
`default_nettype wire

// ----- sv/efc_checker.sv -----
// Port-level assertions for ethercat_frame_checker_unit, with its bind.
// Depends on efc_pkg.
`default_nettype none
module efc_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire efc_pkg::req_word_type req_word,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire efc_pkg::rsp_word_type rsp_word
);
   import efc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_word.frame_end |=> rsp_valid)
      else $error("no result after last byte");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.captured_length != '0
                    && rsp_word.captured_length <= MAX_FRAME + 11'd1)
      else $error("captured length out of range");

   a_ok_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.frame_ok |-> rsp_word.captured_length >= MIN_FRAME
                                          && rsp_word.captured_length <= MAX_FRAME)
      else $error("accepted frame with bad length");

endmodule

bind ethercat_frame_checker_unit efc_checker u_efc_checker (.*);
`default_nettype wire

// ----- test/efc_verdict_checker.sv -----
// Verdict checker for the EtherCAT frame checker testbench: predicts one
// accept/reject word per frame from the accepted bytes and compares results.
// Depends on efc_pkg; instantiated by tb_ethercat_frame_checker_unit.
module efc_verdict_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  efc_pkg::req_word_type req_word,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  efc_pkg::rsp_word_type rsp_word,
   output int                    failures,
   output int                    pending_results
);
   timeunit 1ns;
   timeprecision 1ps;
   import efc_pkg::*;

   localparam int REPORT_LIMIT = 10;

   logic [CountWidth-1:0]  rx_count;
   logic [7:0]             len_lo;
   logic [OffsetWidth-1:0] hdr_end;
   logic [OffsetWidth-1:0] dgram_base;
   logic                   walk_complete;
   logic                   frame_rejected;
   rsp_word_type           expected_verdicts[$];

   function automatic void clear_frame();
      rx_count       = '0;
      len_lo         = '0;
      hdr_end        = '0;
      dgram_base     = HDR_BASE;
      walk_complete  = 1'b0;
      frame_rejected = 1'b0;
   endfunction

   function automatic void inspect_byte(input int unsigned pos, input logic [7:0] b);
      int unsigned count;
      int unsigned next_off;
      logic        more;
      if (pos == POS_TYPE_HI) begin
         if (b != ETHERTYPE_HI) frame_rejected = 1'b1;
      end else if (pos == POS_TYPE_LO) begin
         if (b != ETHERTYPE_LO) frame_rejected = 1'b1;
      end else if (pos == POS_HDR_LO) begin
         len_lo = b;
      end else if (pos == POS_HDR_HI) begin
         hdr_end = HDR_BASE + {1'b0, b[2:0], len_lo};
         if (b[7:4] != HDR_TYPE_PDU || b[3]) frame_rejected = 1'b1;
         if (hdr_end == HDR_BASE) walk_complete = 1'b1;
      end else if (pos >= HDR_BASE && !walk_complete && !frame_rejected) begin
         if (pos == dgram_base + DGRAM_LEN_LO) begin
            len_lo = b;
         end else if (pos == dgram_base + DGRAM_LEN_HI) begin
            count    = {b[2:0], len_lo};
            next_off = dgram_base + DGRAM_OVERHEAD + count;
            more     = b[7];
            if (hdr_end < dgram_base + DGRAM_OVERHEAD) begin
               frame_rejected = 1'b1;
            end else if (next_off > hdr_end) begin
               frame_rejected = 1'b1;
            end else if (more ? (next_off == hdr_end) : (next_off != hdr_end)) begin
               frame_rejected = 1'b1;
            end else if (next_off == hdr_end) begin
               walk_complete = 1'b1;
            end else begin
               dgram_base = next_off[OffsetWidth-1:0];
            end
         end
      end
   endfunction

   function automatic void predict_word(input req_word_type w);
      rsp_word_type verdict;
      if (rx_count <= MAX_FRAME) begin
         inspect_byte(rx_count, w.data_byte);
         rx_count++;
      end
      if (w.frame_end) begin
         verdict.captured_length = rx_count;
         verdict.frame_ok = !frame_rejected && walk_complete && rx_count >= MIN_FRAME
                            && {5'b0, rx_count} == w.wire_length && rx_count <= MAX_FRAME
                            && hdr_end <= rx_count;
         expected_verdicts.push_back(verdict);
         clear_frame();
      end
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         clear_frame();
         expected_verdicts.delete();
         failures = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("%t: unexpected word ok=%0d len=%0d", $realtime,
                           rsp_word.frame_ok, rsp_word.captured_length);
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_word.frame_ok !== want.frame_ok ||
                   rsp_word.captured_length !== want.captured_length) begin
                  failures++;
                  if (failures <= REPORT_LIMIT)
                     $display("%t: verdict mismatch, expected ok=%0d len=%0d, got ok=%0d len=%0d",
                              $realtime, want.frame_ok, want.captured_length,
                              rsp_word.frame_ok, rsp_word.captured_length);
               end
            end
         end
         if (req_valid && req_ready) predict_word(req_word);
      end
      pending_results <= expected_verdicts.size();
   end

endmodule

// ----- test/tb_ethercat_frame_checker_unit.sv -----
// Testbench top for ethercat_frame_checker_unit: builds directed and random
// frames byte by byte, drives both handshakes and prints the verdict.
// Depends on efc_pkg, ethercat_frame_checker_unit and efc_verdict_checker.
module tb_ethercat_frame_checker_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import efc_pkg::*;

   localparam logic [7:0] MORE_FOLLOWS = 8'h80;
   localparam logic [7:0] HDR_RESERVED = 8'h08;
   localparam int         FIRST_LEN_LO = 22;
   localparam int         FIRST_LEN_HI = 23;
   localparam int         HOLD_CYCLES  = 300;
   localparam int         IDLE_PCT     = 21;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_word_type rsp_word;
   int           failures;
   int           pending_results;
   bit           steady;
   bit           hold_request;
   logic [7:0]   frame_q[$];
   int           bytes_sent;
   int           frames_sent;

   ethercat_frame_checker_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   efc_verdict_checker verdict_watch (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_word        (req_word),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_word        (rsp_word),
      .failures        (failures),
      .pending_results (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // result side: random back-pressure, plus one long hold on request
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end
         rsp_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   task automatic send_word(input req_word_type w);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_frame(input logic [15:0] wire_len);
      req_word_type w;
      int           n;
      n = frame_q.size();
      for (int i = 0; i < n; i++) begin
         w.data_byte   = frame_q[i];
         w.frame_end   = (i == n - 1);
         w.wire_length = w.frame_end ? wire_len : 16'($urandom);
         send_word(w);
      end
      bytes_sent += n;
      frames_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   // well-formed frame: ethertype, header and a datagram chain that ends
   // exactly at the header's end, then random padding up to pad_to
   task automatic build_frame(input int dgrams, input int lo_pay, input int hi_pay,
                              input int pad_to);
      logic [10:0] count;
      logic [10:0] hdr_len;
      frame_q.delete();
      repeat (12) frame_q.push_back(8'($urandom));
      frame_q.push_back(ETHERTYPE_HI);
      frame_q.push_back(ETHERTYPE_LO);
      frame_q.push_back(8'h00);
      frame_q.push_back(8'h00);
      for (int d = 0; d < dgrams; d++) begin
         count = 11'($urandom_range(lo_pay, hi_pay));
         repeat (6) frame_q.push_back(8'($urandom));
         frame_q.push_back(count[7:0]);
         frame_q.push_back({(d != dgrams - 1), 4'($urandom), count[10:8]});
         repeat (int'(count) + 4) frame_q.push_back(8'($urandom));
      end
      hdr_len = 11'(frame_q.size() - 16);
      frame_q[POS_HDR_LO] = hdr_len[7:0];
      frame_q[POS_HDR_HI] = {HDR_TYPE_PDU, 1'b0, hdr_len[10:8]};
      while (frame_q.size() < pad_to) frame_q.push_back(8'($urandom));
   endtask

   task automatic truncate_frame(input int keep);
      while (frame_q.size() > keep) void'(frame_q.pop_back());
   endtask

   initial begin
      int          pick;
      int          k;
      int          random_frames;
      logic [15:0] wire_len;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_word     <= '0;
      steady        = 1'b0;
      hold_request  = 1'b0;
      bytes_sent    = 0;
      frames_sent   = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      build_frame(0, 0, 0, MIN_FRAME);
      send_frame(16'(frame_q.size()));
      build_frame(1, 0, 0, MIN_FRAME);
      send_frame(16'(frame_q.size()));
      build_frame(3, 0, 20, MIN_FRAME);
      send_frame(16'(frame_q.size()));
      frame_q.delete();
      repeat (30) frame_q.push_back(8'h00);
      send_frame(16'h0000);
      frame_q.delete();
      repeat (30) frame_q.push_back(8'hff);
      send_frame(16'hffff);
      build_frame(1, 1100, 1490, MAX_FRAME);
      send_frame(16'(frame_q.size()));
      build_frame(1, 0, 200, int'(MAX_FRAME) + 1);
      send_frame(16'(frame_q.size()));
      build_frame(1, 0, 200, 1700);
      send_frame(16'(frame_q.size()));
      build_frame(0, 0, 0, int'(MIN_FRAME) - 1);
      send_frame(16'(frame_q.size()));
      frame_q.delete();
      frame_q.push_back(8'($urandom));
      send_frame(16'd1);
      build_frame(2, 0, 10, MIN_FRAME);
      send_frame(16'(frame_q.size() + 1));
      build_frame(2, 0, 10, MIN_FRAME);
      send_frame(16'(frame_q.size()) | 16'h8000);
      build_frame(1, 0, 10, MIN_FRAME);
      frame_q[POS_TYPE_HI] ^= 8'h01;
      send_frame(16'(frame_q.size()));
      build_frame(1, 0, 10, MIN_FRAME);
      frame_q[POS_TYPE_LO] ^= 8'h01;
      send_frame(16'(frame_q.size()));
      build_frame(1, 0, 10, MIN_FRAME);
      frame_q[POS_HDR_HI] = (frame_q[POS_HDR_HI] & 8'h0f) | 8'h20;
      send_frame(16'(frame_q.size()));
      build_frame(1, 0, 10, MIN_FRAME);
      frame_q[POS_HDR_HI] |= HDR_RESERVED;
      send_frame(16'(frame_q.size()));
      build_frame(1, 20, 30, MIN_FRAME);
      truncate_frame(MIN_FRAME);
      send_frame(16'(frame_q.size()));
      build_frame(1, 0, 10, MIN_FRAME);
      frame_q[FIRST_LEN_HI] |= MORE_FOLLOWS;
      send_frame(16'(frame_q.size()));
      build_frame(2, 0, 10, MIN_FRAME);
      frame_q[FIRST_LEN_HI] &= ~MORE_FOLLOWS;
      send_frame(16'(frame_q.size()));
      build_frame(1, 5, 5, MIN_FRAME);
      frame_q[FIRST_LEN_LO] = 8'd6;
      send_frame(16'(frame_q.size()));
      build_frame(1, 5, 5, MIN_FRAME);
      frame_q[POS_HDR_LO] = 8'd5;
      frame_q[POS_HDR_HI] = {HDR_TYPE_PDU, 4'h0};
      send_frame(16'(frame_q.size()));
      build_frame(2, 10, 10, MIN_FRAME);
      truncate_frame(30);
      send_frame(16'(frame_q.size()));

      random_frames = 0;
      while (bytes_sent < 500 || random_frames < 60) begin
         if (random_frames == 10) steady = 1'b1;
         if (random_frames == 18) steady = 1'b0;
         if (random_frames == 25) hold_request = 1'b1;
         if (random_frames == 35) drain_results();
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 24) == 0)
            build_frame($urandom_range(1, 3), 0, 400, MIN_FRAME);
         else
            build_frame($urandom_range(0, 3), 0, 40, MIN_FRAME);
         repeat ($urandom_range(0, 12)) frame_q.push_back(8'($urandom));
         wire_len = 16'(frame_q.size());
         if (pick < 65) begin
            // clean frame
         end else if (pick < 75) begin
            k = $urandom_range(12, frame_q.size() - 1);
            frame_q[k] ^= 8'($urandom_range(1, 255));
         end else if (pick < 82) begin
            if ($urandom_range(0, 1))
               wire_len = 16'($urandom);
            else
               wire_len = wire_len + 16'($urandom_range(0, 2)) - 16'd1;
         end else if (pick < 90) begin
            truncate_frame($urandom_range(1, frame_q.size() - 1));
            wire_len = 16'(frame_q.size());
         end else begin
            frame_q.delete();
            repeat ($urandom_range(1, 60)) frame_q.push_back(8'($urandom));
            if (frame_q.size() > 13 && $urandom_range(0, 1)) begin
               frame_q[POS_TYPE_HI] = ETHERTYPE_HI;
               frame_q[POS_TYPE_LO] = ETHERTYPE_LO;
            end
            wire_len = $urandom_range(0, 1) ? 16'(frame_q.size()) : 16'($urandom);
         end
         send_frame(wire_len);
         random_frames++;
      end

      drain_results();
      repeat (4) @(posedge clock);
      if (failures == 0 && pending_results == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
